// ----- rtl/tsl_pkg.sv -----
// ----------------------------------------------------------------------------
// tsl_pkg: shared types for the TLS server name locator
// Word formats of the byte and result channels, status codes, and the
// parser-to-output result bundle.
// ----------------------------------------------------------------------------
package tsl_pkg;

    localparam int MAX_BYTES_DEFAULT = 65536;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_HELLO = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_TYPE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] name_offset;
        logic [15:0] name_length;
    } out_word_t;

    typedef struct packed {
        logic      fire;
        out_word_t word;
    } res_t;

endpackage

// ----- rtl/tsl_in_reg.sv -----
// ----------------------------------------------------------------------------
// tsl_in_reg: input register
// Holds one record byte for the parser; stalls the sender while the held
// word cannot advance.
// ----------------------------------------------------------------------------
module tsl_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  tsl_pkg::in_word_t byte_word,
    input  logic             advance,
    output logic             stage_valid,
    output tsl_pkg::in_word_t stage_word
);
    import tsl_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     load;

    assign load        = !valid_reg || advance;
    assign byte_stall  = !load;
    assign valid_next  = load ? byte_valid : valid_reg;
    assign stage_valid = valid_reg;
    assign stage_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && byte_valid)
        begin
            word_reg <= byte_word;
        end
    end

endmodule

// ----- rtl/tsl_parser.sv -----
// ----------------------------------------------------------------------------
// tsl_parser: ClientHello walker
// Updates the parse state for one byte per cycle while the result register can
// take a word, and flags the single result of each record.
// ----------------------------------------------------------------------------
module tsl_parser #(
    parameter int MAX_BYTES = tsl_pkg::MAX_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              stage_valid,
    input  tsl_pkg::in_word_t stage_word,
    input  logic              out_free,
    output logic              advance,
    output tsl_pkg::res_t     res
);
    import tsl_pkg::*;

    localparam int POS_W = $clog2(MAX_BYTES + 1);
    localparam int OFF_W = ((POS_W > 16) ? POS_W : 16) + 1;

    localparam logic [7:0]  TYPE_HANDSHAKE  = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [7:0]  EXT_SERVER_NAME = 8'h00;
    localparam logic [7:0]  NAME_HOST       = 8'h00;
    localparam logic [15:0] SKIP_REC_HDR    = 16'd4;
    localparam logic [15:0] SKIP_FIXED      = 16'd3 + 16'd34;
    localparam logic [15:0] SKIP_LEN2       = 16'd2;
    localparam logic [15:0] SKIP_EXT_HDR    = 16'd4;
    localparam logic [15:0] SKIP_SNI_HDR    = 16'd7;

    typedef enum logic [3:0] {
        PH_TYPE, PH_REC_HDR, PH_HS_TYPE, PH_FIXED,
        PH_SID_LEN, PH_SID, PH_CS_LEN, PH_CS,
        PH_CM_LEN, PH_CM, PH_EXTLEN, PH_EXT_HDR,
        PH_EXT_BODY, PH_SNI_HDR, PH_NAME, PH_DONE
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      skip_reg, skip_next;
    logic [7:0]       lh_reg, lh_next;
    logic [15:0]      hnl_reg, hnl_next;

    phase_t           ph_c;
    logic [15:0]      sk_c;
    logic [7:0]       lh_c;
    logic [15:0]      hnl_c;
    logic             fin;
    status_t          fin_st;
    logic [15:0]      fin_off;
    logic [15:0]      fin_len;
    logic [OFF_W-1:0] off;
    logic [7:0]       b;

    assign advance = stage_valid && out_free;
    assign b       = stage_word.data_byte;

    always_comb
    begin
        ph_c    = phase_reg;
        sk_c    = skip_reg;
        lh_c    = lh_reg;
        hnl_c   = hnl_reg;
        fin     = 1'b0;
        fin_st  = ST_FOUND;
        fin_off = '0;
        fin_len = '0;
        off     = '0;

        if (phase_reg != PH_DONE)
        begin
            if (pos_reg >= POS_W'(MAX_BYTES))
            begin
                fin    = 1'b1;
                fin_st = ST_NOT_FOUND;
            end
            else
            begin
                unique case (phase_reg)
                    PH_TYPE:
                    begin
                        if (b != TYPE_HANDSHAKE)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_NOT_HELLO;
                        end
                        else
                        begin
                            ph_c = PH_REC_HDR;
                            sk_c = SKIP_REC_HDR;
                        end
                    end
                    PH_HS_TYPE:
                    begin
                        if (b != HS_CLIENT_HELLO)
                        begin
                            fin    = 1'b1;
                            fin_st = ST_NOT_HELLO;
                        end
                        else
                        begin
                            ph_c = PH_FIXED;
                            sk_c = SKIP_FIXED;
                        end
                    end
                    PH_SID_LEN:
                    begin
                        ph_c = PH_SID;
                        sk_c = {8'd0, b};
                    end
                    PH_CS_LEN:
                    begin
                        if (skip_reg == 16'd2)
                        begin
                            lh_c = b;
                            sk_c = 16'd1;
                        end
                        else
                        begin
                            ph_c = PH_CS;
                            sk_c = {lh_reg, b};
                        end
                    end
                    PH_CM_LEN:
                    begin
                        ph_c = PH_CM;
                        sk_c = {8'd0, b};
                    end
                    PH_EXT_HDR:
                    begin
                        if (skip_reg == 16'd4)
                        begin
                            lh_c = b;
                            sk_c = 16'd3;
                        end
                        else if (skip_reg == 16'd3)
                        begin
                            if (lh_reg == EXT_SERVER_NAME && b == EXT_SERVER_NAME)
                            begin
                                ph_c = PH_SNI_HDR;
                                sk_c = SKIP_SNI_HDR;
                            end
                            else
                            begin
                                sk_c = 16'd2;
                            end
                        end
                        else if (skip_reg == 16'd2)
                        begin
                            lh_c = b;
                            sk_c = 16'd1;
                        end
                        else
                        begin
                            ph_c = PH_EXT_BODY;
                            sk_c = {lh_reg, b};
                        end
                    end
                    PH_SNI_HDR:
                    begin
                        if (skip_reg == 16'd3)
                        begin
                            hnl_c = {8'd0, b};
                            sk_c  = 16'd2;
                        end
                        else if (skip_reg == 16'd2)
                        begin
                            lh_c = b;
                            sk_c = 16'd1;
                        end
                        else if (skip_reg == 16'd1)
                        begin
                            if (hnl_reg != {8'd0, NAME_HOST})
                            begin
                                fin    = 1'b1;
                                fin_st = ST_BAD_TYPE;
                            end
                            else
                            begin
                                hnl_c = {lh_reg, b};
                                ph_c  = PH_NAME;
                                sk_c  = {lh_reg, b};
                            end
                        end
                        else
                        begin
                            sk_c = skip_reg - 16'd1;
                        end
                    end
                    PH_REC_HDR, PH_FIXED, PH_SID, PH_CS, PH_CM,
                    PH_EXTLEN, PH_EXT_BODY, PH_NAME:
                    begin
                        if (skip_reg != 16'd0)
                        begin
                            sk_c = skip_reg - 16'd1;
                        end
                    end
                    PH_DONE:
                    begin
                    end
                endcase

                if (!fin && sk_c == 16'd0)
                begin
                    unique case (ph_c)
                        PH_REC_HDR:  ph_c = PH_HS_TYPE;
                        PH_FIXED:    ph_c = PH_SID_LEN;
                        PH_SID:
                        begin
                            ph_c = PH_CS_LEN;
                            sk_c = SKIP_LEN2;
                        end
                        PH_CS:       ph_c = PH_CM_LEN;
                        PH_CM:
                        begin
                            ph_c = PH_EXTLEN;
                            sk_c = SKIP_LEN2;
                        end
                        PH_EXTLEN, PH_EXT_BODY:
                        begin
                            ph_c = PH_EXT_HDR;
                            sk_c = SKIP_EXT_HDR;
                        end
                        PH_NAME:
                        begin
                            off = OFF_W'(pos_reg) + OFF_W'(1) - OFF_W'(hnl_c);
                            fin = 1'b1;
                            if (off >= OFF_W'(MAX_BYTES))
                            begin
                                fin_st = ST_NOT_FOUND;
                            end
                            else
                            begin
                                fin_st  = ST_FOUND;
                                fin_off = off[15:0];
                                fin_len = hnl_c;
                            end
                        end
                        PH_TYPE, PH_HS_TYPE, PH_SID_LEN, PH_CS_LEN, PH_CM_LEN,
                        PH_EXT_HDR, PH_SNI_HDR, PH_DONE:
                        begin
                        end
                    endcase
                end
            end

            if (stage_word.last_byte && !fin)
            begin
                fin    = 1'b1;
                fin_st = ST_NOT_FOUND;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        skip_next  = skip_reg;
        lh_next    = lh_reg;
        hnl_next   = hnl_reg;
        if (advance)
        begin
            phase_next = fin ? PH_DONE : ph_c;
            skip_next  = sk_c;
            lh_next    = lh_c;
            hnl_next   = hnl_c;
            if (pos_reg < POS_W'(MAX_BYTES))
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            if (stage_word.last_byte)
            begin
                phase_next = PH_TYPE;
                pos_next   = '0;
                skip_next  = '0;
                lh_next    = '0;
                hnl_next   = '0;
            end
        end
    end

    assign res.fire             = advance && fin;
    assign res.word.status      = fin_st;
    assign res.word.name_offset = fin_off;
    assign res.word.name_length = fin_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TYPE;
            pos_reg   <= '0;
            skip_reg  <= '0;
            lh_reg    <= '0;
            hnl_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            lh_reg    <= lh_next;
            hnl_reg   <= hnl_next;
        end
    end

endmodule

// ----- rtl/tsl_out_reg.sv -----
// ----------------------------------------------------------------------------
// tsl_out_reg: result register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module tsl_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  tsl_pkg::res_t      res,
    output logic               out_free,
    output logic               result_valid,
    input  logic               result_stall,
    output tsl_pkg::out_word_t result_word
);
    import tsl_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    assign out_free     = !valid_reg || !result_stall;
    assign valid_next   = out_free ? res.fire : valid_reg;
    assign result_valid = valid_reg;
    assign result_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.fire)
        begin
            word_reg <= res.word;
        end
    end

endmodule

// ----- rtl/tls_sni_locator.sv -----
// ----------------------------------------------------------------------------
// tls_sni_locator: TLS ClientHello server name locator
// Walks a reassembled TLS record one byte per word and reports the host
// name's offset and length, or a status, once per record.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the result register can take a word, a rate
// set by the parse state update in tsl_parser, and gives exactly one result
// word per record, from the byte that decides it via the input register, then
// the result register; the last byte of a record always ends it. Positions
// count up to MAX_BYTES; a record still undecided after that many bytes reports
// not found. No clearing pass is needed after reset.
module tls_sni_locator #(
    parameter int MAX_BYTES = tsl_pkg::MAX_BYTES_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  tsl_pkg::in_word_t  byte_word,
    output logic               result_valid,
    input  logic               result_stall,
    output tsl_pkg::out_word_t result_word
);
    import tsl_pkg::*;

    logic     stage_valid;
    in_word_t stage_word;
    logic     advance;
    logic     out_free;
    res_t     res;

    tsl_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_word   (byte_word),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_word  (stage_word)
    );

    tsl_parser #(
        .MAX_BYTES (MAX_BYTES)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_word  (stage_word),
        .out_free    (out_free),
        .advance     (advance),
        .res         (res)
    );

    tsl_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .res          (res),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

endmodule

// ----- test/tb_tls_sni_locator.sv -----
// ----------------------------------------------------------------------------
// tb_tls_sni_locator: self-checking bench for the TLS server name locator
// Feeds ClientHello records byte by byte (well-formed hellos with random
// content, bad name types, records without a server name, cut-off records,
// wrong content or handshake types and plain noise), predicts the one result
// of every record with a byte-level parser model, and checks each result word
// against it. Both sides idle and stall at random; a long result hold-off
// fills the block.
// ----------------------------------------------------------------------------
module tb_tls_sni_locator;

    import tsl_pkg::*;

    localparam logic [16:0] MAX_POS         = 17'(MAX_BYTES_DEFAULT);
    localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
    localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
    localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
    localparam logic [7:0]  NAME_HOST       = 8'h00;
    localparam int          REC_HDR_REST    = 4;
    localparam int          HS_LEN_BYTES    = 3;
    localparam int          FIXED_BYTES     = 34;
    localparam int          HELLO_NAME      = 0;
    localparam int          HELLO_BAD_TYPE  = 1;
    localparam int          HELLO_BARE      = 2;
    localparam int          ITEM_TARGET     = 550;
    localparam int          HOLD_RECORDS    = 16;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          TAIL_CYCLES     = 16;
    localparam int          CYCLE_LIMIT     = 1500000;

    typedef enum logic [3:0] {
        P_CTYPE, P_RECHDR, P_HSTYPE, P_FIXED, P_SIDLEN, P_SID, P_CSLEN, P_SUITES,
        P_CMLEN, P_COMP, P_EXTLEN, P_EXTHDR, P_EXTBODY, P_SNIHDR, P_NAME, P_DONE
    } walk_phase_e;

    class sni_tracker;
        out_word_t   due_results[$];
        int          errors;
        walk_phase_e phase;
        logic [16:0] pos;
        logic [15:0] skip;
        logic [15:0] host_len;
        logic [7:0]  len_hi;
        bit          given;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase    = P_CTYPE;
            pos      = '0;
            skip     = '0;
            host_len = '0;
            len_hi   = '0;
            given    = 1'b0;
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction

        function void conclude(status_t st, logic [15:0] off, logic [15:0] len);
            out_word_t r;
            r.status      = st;
            r.name_offset = off;
            r.name_length = len;
            due_results.push_back(r);
            given = 1'b1;
            phase = P_DONE;
        endfunction

        function bit counting(walk_phase_e ph);
            case (ph)
                P_RECHDR, P_FIXED, P_SID, P_SUITES, P_COMP, P_EXTLEN, P_EXTBODY, P_NAME:
                    return 1'b1;
                default:
                    return 1'b0;
            endcase
        endfunction

        // leave every counted field whose count has run out
        function void advance_skips(logic [16:0] p);
            logic [16:0] off;
            while (counting(phase) && skip == 16'd0) begin
                case (phase)
                    P_RECHDR: phase = P_HSTYPE;
                    P_FIXED:  phase = P_SIDLEN;
                    P_SID:
                    begin
                        phase = P_CSLEN;
                        skip  = 16'd2;
                    end
                    P_SUITES: phase = P_CMLEN;
                    P_COMP:
                    begin
                        phase = P_EXTLEN;
                        skip  = 16'd2;
                    end
                    P_EXTLEN, P_EXTBODY:
                    begin
                        phase = P_EXTHDR;
                        skip  = 16'd4;
                    end
                    default:
                    begin
                        off = p + 17'd1 - {1'b0, host_len};
                        if (off >= MAX_POS)
                            conclude(ST_NOT_FOUND, 16'd0, 16'd0);
                        else
                            conclude(ST_FOUND, off[15:0], host_len);
                    end
                endcase
            end
        endfunction

        function void walk_byte(logic [7:0] b, logic [16:0] p);
            case (phase)
                P_CTYPE:
                begin
                    if (b != REC_HANDSHAKE)
                    begin
                        conclude(ST_NOT_HELLO, 16'd0, 16'd0);
                        return;
                    end
                    phase = P_RECHDR;
                    skip  = 16'(REC_HDR_REST);
                end
                P_HSTYPE:
                begin
                    if (b != HS_CLIENT_HELLO)
                    begin
                        conclude(ST_NOT_HELLO, 16'd0, 16'd0);
                        return;
                    end
                    phase = P_FIXED;
                    skip  = 16'(HS_LEN_BYTES + FIXED_BYTES);
                end
                P_SIDLEN:
                begin
                    phase = P_SID;
                    skip  = {8'd0, b};
                end
                P_CSLEN:
                begin
                    if (skip == 16'd2)
                    begin
                        len_hi = b;
                        skip   = 16'd1;
                    end
                    else
                    begin
                        phase = P_SUITES;
                        skip  = {len_hi, b};
                    end
                end
                P_CMLEN:
                begin
                    phase = P_COMP;
                    skip  = {8'd0, b};
                end
                P_EXTHDR:
                begin
                    if (skip == 16'd4)
                    begin
                        len_hi = b;
                        skip   = 16'd3;
                    end
                    else if (skip == 16'd3)
                    begin
                        if ({len_hi, b} == EXT_SERVER_NAME)
                        begin
                            phase = P_SNIHDR;
                            skip  = 16'd7;
                        end
                        else
                            skip = 16'd2;
                    end
                    else if (skip == 16'd2)
                    begin
                        len_hi = b;
                        skip   = 16'd1;
                    end
                    else
                    begin
                        phase = P_EXTBODY;
                        skip  = {len_hi, b};
                    end
                end
                P_SNIHDR:
                begin
                    if (skip == 16'd3)
                    begin
                        host_len = {8'd0, b};
                        skip     = 16'd2;
                    end
                    else if (skip == 16'd2)
                    begin
                        len_hi = b;
                        skip   = 16'd1;
                    end
                    else if (skip == 16'd1)
                    begin
                        if (host_len != {8'd0, NAME_HOST})
                        begin
                            conclude(ST_BAD_TYPE, 16'd0, 16'd0);
                            return;
                        end
                        host_len = {len_hi, b};
                        phase    = P_NAME;
                        skip     = host_len;
                    end
                    else
                        skip = skip - 16'd1;
                end
                P_DONE:
                    return;
                default:
                    if (skip != 16'd0)
                        skip = skip - 16'd1;
            endcase
            advance_skips(p);
        endfunction

        function void note_byte(in_word_t w);
            if (!given)
            begin
                if (pos >= MAX_POS)
                    conclude(ST_NOT_FOUND, 16'd0, 16'd0);
                else
                    walk_byte(w.data_byte, pos);
            end
            if (pos < MAX_POS)
                pos = pos + 17'd1;
            if (w.last_byte && !given)
                conclude(ST_NOT_FOUND, 16'd0, 16'd0);
            if (w.last_byte)
                clear();
        endfunction

        function void check(out_word_t got);
            out_word_t want;
            if (due_results.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d offset %0d length %0d",
                         $time, got.status, got.name_offset, got.name_length);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.status !== want.status || got.name_offset !== want.name_offset ||
                got.name_length !== want.name_length)
            begin
                $display("%0t: expected status %0d offset %0d length %0d, got %0d %0d %0d",
                         $time, want.status, want.name_offset, want.name_length,
                         got.status, got.name_offset, got.name_length);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_word_t  byte_word;
    logic      result_valid;
    logic      result_stall;
    out_word_t result_word;

    sni_tracker sb = new();
    logic [7:0] rec[$];
    int         burst_left = 0;
    int         sent_bytes = 0;
    bit         hold_results = 1'b0;

    tls_sni_locator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_word    (byte_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void put_rand(int n);
        repeat (n) rec.push_back(8'($urandom));
    endfunction

    function automatic void put_hello_head(int sid, int cs, int cm);
        rec.push_back(REC_HANDSHAKE);
        put_rand(REC_HDR_REST);
        rec.push_back(HS_CLIENT_HELLO);
        put_rand(HS_LEN_BYTES + FIXED_BYTES);
        rec.push_back(8'(sid));
        put_rand(sid);
        rec.push_back(8'(cs >> 8));
        rec.push_back(8'(cs));
        put_rand(cs);
        rec.push_back(8'(cm));
        put_rand(cm);
        put_rand(2);
    endfunction

    function automatic void put_ext(int kind, int len);
        rec.push_back(8'(kind >> 8));
        rec.push_back(8'(kind));
        rec.push_back(8'(len >> 8));
        rec.push_back(8'(len));
        put_rand(len);
    endfunction

    function automatic void put_sni(logic [7:0] kind_byte, int name_len);
        rec.push_back(EXT_SERVER_NAME[15:8]);
        rec.push_back(EXT_SERVER_NAME[7:0]);
        put_rand(4);
        rec.push_back(kind_byte);
        rec.push_back(8'(name_len >> 8));
        rec.push_back(8'(name_len));
        put_rand(name_len);
    endfunction

    function automatic int other_ext_kind();
        case ($urandom_range(0, 2))
            0:       return $urandom_range(1, 255);
            1:       return $urandom_range(1, 255) << 8;
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    function automatic void put_random_hello(int flavor);
        int sid;
        int cs;
        int name_len;
        sid = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 32);
        cs  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : 2 * $urandom_range(0, 12);
        name_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(0, 24);
        put_hello_head(sid, cs, $urandom_range(0, 3));
        repeat ($urandom_range(0, 3)) put_ext(other_ext_kind(), $urandom_range(0, 12));
        case (flavor)
            HELLO_NAME:     put_sni(NAME_HOST, name_len);
            HELLO_BAD_TYPE: put_sni(8'($urandom_range(1, 255)), name_len);
            default:        put_ext(other_ext_kind(), $urandom_range(0, 12));
        endcase
        put_rand($urandom_range(0, 4));
    endfunction

    function automatic void cut_record(int keep);
        while (rec.size() > keep) rec.delete(rec.size() - 1);
    endfunction

    task automatic send_record(bit steady);
        in_word_t w;
        int       gap;
        for (int i = 0; i < rec.size(); i++)
        begin
            if (!steady && burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    byte_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            if (burst_left > 0)
                burst_left--;
            w.data_byte = rec[i];
            w.last_byte = (i == rec.size() - 1);
            byte_word  <= w;
            byte_valid <= 1'b1;
            @(posedge clk);
            while (byte_stall) @(posedge clk);
            sb.note_byte(w);
            sent_bytes++;
            @(negedge clk);
        end
        rec.delete();
    endtask

    task automatic drain();
        byte_valid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0) @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check(result_word);
    end

    initial
    begin : rx_side
        int mode_left;
        int stall_pct;
        mode_left    = 0;
        stall_pct    = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_results = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(10, 200);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            mode_left--;
            result_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int pick;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_word  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed records
        rec.push_back(REC_HANDSHAKE);
        send_record(1'b1);
        rec.push_back(8'h00);
        send_record(1'b0);
        rec.push_back(8'hFF);
        put_rand(3);
        send_record(1'b1);
        rec.push_back(REC_HANDSHAKE);
        put_rand(REC_HDR_REST);
        send_record(1'b0);
        rec.push_back(REC_HANDSHAKE);
        put_rand(REC_HDR_REST);
        rec.push_back(8'h02);
        put_rand(6);
        send_record(1'b1);
        rec.push_back(REC_HANDSHAKE);
        put_rand(REC_HDR_REST);
        rec.push_back(8'hFF);
        send_record(1'b0);
        put_hello_head(0, 0, 0);
        put_sni(NAME_HOST, 5);
        send_record(1'b1);
        put_hello_head(2, 2, 1);
        put_ext(16'h0001, 0);
        put_ext(16'h0100, 3);
        put_ext(16'hFFFF, 1);
        put_sni(NAME_HOST, 6);
        put_rand(2);
        send_record(1'b0);
        put_hello_head(0, 0, 0);
        put_sni(NAME_HOST, 0);
        put_rand(3);
        send_record(1'b1);
        put_hello_head(0, 0, 0);
        put_sni(8'hFF, 2);
        send_record(1'b0);
        put_hello_head(1, 2, 0);
        put_ext(16'h000A, 4);
        put_ext(16'h0017, 0);
        send_record(1'b0);
        put_hello_head(0, 2, 1);
        put_sni(NAME_HOST, 12);
        cut_record(rec.size() - 4);
        send_record(1'b1);
        put_hello_head(2, 2, 2);
        cut_record(30);
        send_record(1'b1);

        // hold off results while short records keep coming
        hold_results = 1'b1;
        repeat (HOLD_RECORDS)
        begin
            put_rand($urandom_range(1, 3));
            send_record(1'b1);
        end
        drain();

        while (sent_bytes < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                put_random_hello(HELLO_NAME);
            else if (pick < 65)
                put_random_hello(HELLO_BAD_TYPE);
            else if (pick < 73)
                put_random_hello(HELLO_BARE);
            else if (pick < 85)
            begin
                put_random_hello(HELLO_NAME);
                cut_record($urandom_range(1, rec.size()));
            end
            else if (pick < 92)
            begin
                rec.push_back(($urandom_range(0, 1) == 0) ? 8'($urandom) : REC_HANDSHAKE);
                put_rand(REC_HDR_REST);
                rec.push_back(8'($urandom));
                put_rand($urandom_range(0, 8));
            end
            else
                put_rand($urandom_range(1, 12));
            send_record($urandom_range(0, 5) == 0);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- tls_sni_locator.f -----
rtl/tsl_pkg.sv
rtl/tsl_in_reg.sv
rtl/tsl_parser.sv
rtl/tsl_out_reg.sv
rtl/tls_sni_locator.sv
test/tb_tls_sni_locator.sv
